### src/fuzzy_two_input_controller_assert.svh
// Assertion macros for the fuzzy controller.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FUZZY_TWO_INPUT_CONTROLLER_ASSERT_SVH
`define FUZZY_TWO_INPUT_CONTROLLER_ASSERT_SVH

// overlapping implication, cons may hold a ## delay
`define FZC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// plain condition that must hold on every edge
`define FZC_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

### src/fzc_pkg.sv
// Types, constants, set table and rule table for the fuzzy controller.
// No dependencies.
package fzc_pkg;

  localparam int NUM_SETS           = 5;
  localparam int NUM_UNITS          = 2 * NUM_SETS;
  localparam int NUM_LEVELS         = 5;
  localparam int NUM_RULES_MAX      = 25;
  localparam int NUM_RULES_DEF      = 25;
  localparam int MIN_WEIGHT_SUM_DEF = 1;
  localparam int GROUP_SIZE         = 5;
  localparam int NUM_GROUPS         = NUM_RULES_MAX / GROUP_SIZE;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int GRADE_W   = 13;
  localparam int NUM_W     = 15;
  localparam int FRAC_W    = 12;
  localparam int P_W       = NUM_W + FRAC_W;
  localparam int RECIP_W   = 24;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W    = 29;
  localparam int WSUM_W    = 17;
  localparam int NUM_SUM_W = 33;
  localparam int DIVD_W    = 34;
  localparam int QUO_W     = 17;
  localparam int LATENCY   = 26;

  localparam logic [GRADE_W-1:0] GRADE_ONE = 13'd4096;

  typedef enum logic [1:0] {GK_ZERO, GK_ONE, GK_RAMP} gkind_e;
  typedef enum logic [2:0] {DEN_8192, DEN_10240, DEN_14336, DEN_573, DEN_574} den_e;
  typedef enum logic [1:0] {SH_LEFT, SH_RIGHT, SH_REG} shape_e;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LVL_NM, REG_LVL_NS, REG_LVL_ZE, REG_LVL_PS, REG_LVL_PM
  } reg_idx_e;

  typedef struct packed {
    shape_e            shape;
    logic signed [16:0] a;
    logic signed [16:0] b;
    logic signed [16:0] c;
    logic signed [16:0] d;
    den_e              rise;
    den_e              fall;
  } fset_t;

  typedef struct packed {
    gkind_e           kind;
    logic [NUM_W-1:0] num;
    den_e             den;
  } greq_t;

  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [WSUM_W-1:0] den;
    logic              neg;
    logic              no_fire;
  } dstage_t;

  localparam fset_t X_SETS [NUM_SETS] = '{
    '{SH_LEFT,  -17'sd22528, -17'sd14336, 17'sd0,      17'sd0,     DEN_8192,  DEN_8192},
    '{SH_REG,   -17'sd24576, -17'sd14336, -17'sd10240, 17'sd0,     DEN_10240, DEN_10240},
    '{SH_REG,   -17'sd14336, 17'sd0,      17'sd0,      17'sd14336, DEN_14336, DEN_14336},
    '{SH_REG,   17'sd0,      17'sd10240,  17'sd14336,  17'sd24576, DEN_10240, DEN_10240},
    '{SH_RIGHT, 17'sd14336,  17'sd22528,  17'sd0,      17'sd0,     DEN_8192,  DEN_8192}
  };

  localparam fset_t Y_SETS [NUM_SETS] = '{
    '{SH_LEFT,  -17'sd1147, -17'sd573, 17'sd0,    17'sd0,    DEN_574, DEN_574},
    '{SH_REG,   -17'sd1147, -17'sd573, -17'sd573, 17'sd0,    DEN_574, DEN_573},
    '{SH_REG,   -17'sd573,  17'sd0,    17'sd0,    17'sd573,  DEN_573, DEN_573},
    '{SH_REG,   17'sd0,     17'sd573,  17'sd573,  17'sd1147, DEN_573, DEN_574},
    '{SH_RIGHT, 17'sd573,   17'sd1147, 17'sd0,    17'sd0,    DEN_574, DEN_574}
  };

  // rules in row-major order: X set, Y set, level
  localparam logic [2:0] RULE_X [NUM_RULES_MAX] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };
  localparam logic [2:0] RULE_Y [NUM_RULES_MAX] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };
  localparam logic [2:0] RULE_L [NUM_RULES_MAX] = '{
    3'd1, 3'd3, 3'd3, 3'd4, 3'd3, 3'd1, 3'd1, 3'd3, 3'd4, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd1, 3'd3, 3'd3,
    3'd1, 3'd0, 3'd1, 3'd2, 3'd3
  };

  localparam logic signed [DATA_W-1:0] LEVEL_RESET [NUM_LEVELS] = '{
    -16'sd2800, -16'sd1200, 16'sd0, 16'sd1200, 16'sd2800
  };

  localparam logic [RECIP_W-1:0] RECIP_8192  = RECIP_W'((64'd1 << RECIP_SHIFT) / 8192);
  localparam logic [RECIP_W-1:0] RECIP_10240 = RECIP_W'((64'd1 << RECIP_SHIFT) / 10240);
  localparam logic [RECIP_W-1:0] RECIP_14336 = RECIP_W'((64'd1 << RECIP_SHIFT) / 14336);
  localparam logic [RECIP_W-1:0] RECIP_573   = RECIP_W'((64'd1 << RECIP_SHIFT) / 573);
  localparam logic [RECIP_W-1:0] RECIP_574   = RECIP_W'((64'd1 << RECIP_SHIFT) / 574);

  function automatic logic [NUM_W-1:0] den_value(den_e code);
    logic [NUM_W-1:0] v;
    case (code)
      DEN_8192:  v = 15'd8192;
      DEN_10240: v = 15'd10240;
      DEN_14336: v = 15'd14336;
      DEN_573:   v = 15'd573;
      DEN_574:   v = 15'd574;
      default:   v = 15'd8192;
    endcase
    return v;
  endfunction

  function automatic logic [RECIP_W-1:0] den_recip(den_e code);
    logic [RECIP_W-1:0] v;
    case (code)
      DEN_8192:  v = RECIP_8192;
      DEN_10240: v = RECIP_10240;
      DEN_14336: v = RECIP_14336;
      DEN_573:   v = RECIP_573;
      DEN_574:   v = RECIP_574;
      default:   v = RECIP_8192;
    endcase
    return v;
  endfunction

  // classify x against one set: constant grade or flank numerator
  function automatic greq_t grade_req(logic signed [16:0] x, fset_t s);
    greq_t             r;
    logic signed [17:0] diff;
    r.kind = GK_ZERO;
    r.den  = s.rise;
    diff   = '0;
    case (s.shape)
      SH_LEFT: begin
        if (x <= s.a) begin
          r.kind = GK_ONE;
        end else if (x < s.b) begin
          r.kind = GK_RAMP;
          diff   = 18'(s.b) - 18'(x);
        end
      end
      SH_RIGHT: begin
        if (x >= s.b) begin
          r.kind = GK_ONE;
        end else if (x > s.a) begin
          r.kind = GK_RAMP;
          diff   = 18'(x) - 18'(s.a);
        end
      end
      default: begin
        if (x <= s.a || x >= s.d) begin
          r.kind = GK_ZERO;
        end else if (x >= s.b && x <= s.c) begin
          r.kind = GK_ONE;
        end else if (x < s.b) begin
          r.kind = GK_RAMP;
          diff   = 18'(x) - 18'(s.a);
        end else begin
          r.kind = GK_RAMP;
          r.den  = s.fall;
          diff   = 18'(s.d) - 18'(x);
        end
      end
    endcase
    r.num = diff[NUM_W-1:0];
    return r;
  endfunction

endpackage

### src/fzc_grade.sv
// Membership grading: ten trapezoid sets, flank division by reciprocal.
// Three register stages. Depends on fzc_pkg.
module fzc_grade import fzc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [DATA_W-1:0]  pos_x_i,
  input  logic signed [DATA_W-1:0]  angle_y_i,
  output logic                      valid_o,
  output logic [GRADE_W-1:0]        gx_o [NUM_SETS],
  output logic [GRADE_W-1:0]        gy_o [NUM_SETS]
);

  greq_t                req_d  [NUM_UNITS];
  greq_t                req1_q [NUM_UNITS];
  logic                 vld1_q, vld2_q, vld3_q;

  logic [GRADE_W-1:0]   qest_d [NUM_UNITS];
  logic [GRADE_W-1:0]   qest2_q [NUM_UNITS];
  greq_t                req2_q [NUM_UNITS];

  logic [GRADE_W-1:0]   grade_d [NUM_UNITS];
  logic [GRADE_W-1:0]   grade3_q [NUM_UNITS];

  // stage 1: classify
  always_comb begin
    for (int s = 0; s < NUM_SETS; s++) begin
      req_d[s]            = grade_req(17'(pos_x_i), X_SETS[s]);
      req_d[s + NUM_SETS] = grade_req(17'(angle_y_i), Y_SETS[s]);
    end
  end

  // stage 2: quotient estimate, low by at most one
  always_comb begin
    logic [P_W+RECIP_W-1:0] prod;
    prod = '0;
    for (int u = 0; u < NUM_UNITS; u++) begin
      prod = (P_W+RECIP_W)'({req1_q[u].num, {FRAC_W{1'b0}}})
           * (P_W+RECIP_W)'(den_recip(req1_q[u].den));
      qest_d[u] = prod[RECIP_SHIFT +: GRADE_W];
    end
  end

  // stage 3: correct estimate and pick final grade
  always_comb begin
    logic [P_W:0] rem;
    rem = '0;
    for (int u = 0; u < NUM_UNITS; u++) begin
      rem = (P_W+1)'({req2_q[u].num, {FRAC_W{1'b0}}})
          - (P_W+1)'(qest2_q[u]) * (P_W+1)'(den_value(req2_q[u].den));
      case (req2_q[u].kind)
        GK_ONE:  grade_d[u] = GRADE_ONE;
        GK_RAMP: grade_d[u] = (rem >= (P_W+1)'(den_value(req2_q[u].den)))
                              ? qest2_q[u] + 1'b1 : qest2_q[u];
        default: grade_d[u] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req1_q   <= req_d;
    req2_q   <= req1_q;
    qest2_q  <= qest_d;
    grade3_q <= grade_d;
  end

  assign valid_o = vld3_q;

  always_comb begin
    for (int s = 0; s < NUM_SETS; s++) begin
      gx_o[s] = grade3_q[s];
      gy_o[s] = grade3_q[s + NUM_SETS];
    end
  end

endmodule

### src/fzc_rules.sv
// Rule firing: min of grades, weighted levels, registered adder tree.
// Four register stages. Depends on fzc_pkg.
module fzc_rules import fzc_pkg::*; #(
  parameter int NUM_RULES = NUM_RULES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [GRADE_W-1:0]          gx_i [NUM_SETS],
  input  logic [GRADE_W-1:0]          gy_i [NUM_SETS],
  input  logic signed [DATA_W-1:0]    lvl_i [NUM_LEVELS],
  output logic                        valid_o,
  output logic signed [NUM_SUM_W-1:0] num_o,
  output logic [WSUM_W-1:0]           den_o
);

  logic [GRADE_W-1:0]          w_d [NUM_RULES_MAX];
  logic [GRADE_W-1:0]          w_q [NUM_RULES_MAX];
  logic signed [PROD_W-1:0]    prod_d [NUM_RULES_MAX];
  logic signed [PROD_W-1:0]    prod_q [NUM_RULES_MAX];
  logic [WSUM_W-1:0]           wsum_d [NUM_GROUPS];
  logic [WSUM_W-1:0]           wsum_q [NUM_GROUPS];
  logic signed [NUM_SUM_W-1:0] psum_d [NUM_GROUPS];
  logic signed [NUM_SUM_W-1:0] psum_q [NUM_GROUPS];
  logic [WSUM_W-1:0]           den_d, den3_q, den4_q;
  logic signed [NUM_SUM_W-1:0] num_d, num4_q;
  logic                        vld1_q, vld2_q, vld3_q, vld4_q;

  // rules past NUM_RULES carry no weight
  always_comb begin
    for (int i = 0; i < NUM_RULES_MAX; i++) begin
      if (i < NUM_RULES) begin
        w_d[i] = (gx_i[RULE_X[i]] < gy_i[RULE_Y[i]]) ? gx_i[RULE_X[i]] : gy_i[RULE_Y[i]];
      end else begin
        w_d[i] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_RULES_MAX; i++) begin
      prod_d[i] = PROD_W'($signed({1'b0, w_q[i]})) * PROD_W'(lvl_i[RULE_L[i]]);
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      wsum_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        wsum_d[g] = wsum_d[g] + WSUM_W'(w_q[g*GROUP_SIZE + j]);
      end
    end
  end

  always_comb begin
    den_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      psum_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        psum_d[g] = psum_d[g] + NUM_SUM_W'(prod_q[g*GROUP_SIZE + j]);
      end
      den_d = den_d + wsum_q[g];
    end
  end

  always_comb begin
    num_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      num_d = num_d + psum_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    prod_q <= prod_d;
    wsum_q <= wsum_d;
    psum_q <= psum_d;
    den3_q <= den_d;
    num4_q <= num_d;
    den4_q <= den3_q;
  end

  assign valid_o = vld4_q;
  assign num_o   = num4_q;
  assign den_o   = den4_q;

endmodule

### src/fzc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with
// rounding, weak-firing check and positive saturation. Depends on fzc_pkg.
module fzc_div import fzc_pkg::*; #(
  parameter int MIN_WEIGHT_SUM = MIN_WEIGHT_SUM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [NUM_SUM_W-1:0] num_i,
  input  logic [WSUM_W-1:0]           den_i,
  output logic                        valid_o,
  output logic signed [DATA_W-1:0]    drive_force_o,
  output logic                        no_rule_fired_o
);

  dstage_t                  entry_d;
  dstage_t                  st_q [QUO_W+1];
  dstage_t                  st_d [QUO_W+1];
  logic                     vld_q [QUO_W+1];
  logic                     out_vld_q;
  logic signed [DATA_W-1:0] drive_d, drive_q;
  logic                     flag_d, flag_q;

  // magnitude plus half the divisor gives round half away from zero
  always_comb begin
    logic [NUM_SUM_W-1:0] mag;
    mag             = (num_i < 0) ? NUM_SUM_W'(-num_i) : NUM_SUM_W'(num_i);
    entry_d.neg     = (num_i < 0);
    entry_d.rem     = DIVD_W'(mag) + DIVD_W'(den_i >> 1);
    entry_d.quo     = '0;
    entry_d.den     = den_i;
    entry_d.no_fire = (den_i < WSUM_W'(MIN_WEIGHT_SUM));
  end

  always_comb begin
    logic [DIVD_W:0] trial;
    trial   = '0;
    st_d[0] = entry_d;
    for (int s = 1; s <= QUO_W; s++) begin
      st_d[s] = st_q[s-1];
      trial   = (DIVD_W+1)'(st_q[s-1].den) << (QUO_W - s);
      if ((DIVD_W+1)'(st_q[s-1].rem) >= trial) begin
        st_d[s].rem           = DIVD_W'((DIVD_W+1)'(st_q[s-1].rem) - trial);
        st_d[s].quo[QUO_W-s]  = 1'b1;
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0] neg_mag;
    neg_mag = -st_q[QUO_W].quo;
    flag_d  = st_q[QUO_W].no_fire;
    if (st_q[QUO_W].no_fire) begin
      drive_d = '0;
    end else if (st_q[QUO_W].neg) begin
      drive_d = neg_mag[DATA_W-1:0];
    end else if (st_q[QUO_W].quo > QUO_W'(16'h7fff)) begin
      drive_d = 16'sh7fff;
    end else begin
      drive_d = st_q[QUO_W].quo[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QUO_W; s++) begin
        vld_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s <= QUO_W; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      out_vld_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    drive_q <= drive_d;
    flag_q  <= flag_d;
  end

  assign valid_o         = out_vld_q;
  assign drive_force_o   = drive_q;
  assign no_rule_fired_o = flag_q;

endmodule

### src/fuzzy_two_input_controller.sv
// Top level of the two-input fuzzy controller: level registers and pipeline.
// Depends on fzc_pkg, fzc_grade, fzc_rules, fzc_div and the assert header.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  sample    | start_i / busy_o   | pos_x_i, angle_y_i
//  result    | done_o (strobe)    | drive_force_o, no_rule_fired_o
//  config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// One sample enters every cycle; busy_o stays low.
// The pipeline has 3 grading stages, 4 rule/sum stages, and a
// 19-stage divider (entry, one stage per quotient bit, output).
// Reset clears the valid bits and reloads the five drive levels.
// Results are strobed for one cycle and are never held back.
module fuzzy_two_input_controller import fzc_pkg::*; #(
  parameter int NUM_RULES      = NUM_RULES_DEF,
  parameter int MIN_WEIGHT_SUM = MIN_WEIGHT_SUM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] angle_y_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] drive_force_o,
  output logic                     no_rule_fired_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i
);

  `include "fuzzy_two_input_controller_assert.svh"

  logic signed [DATA_W-1:0]    lvl_q [NUM_LEVELS];
  logic                        grd_vld;
  logic [GRADE_W-1:0]          gx [NUM_SETS];
  logic [GRADE_W-1:0]          gy [NUM_SETS];
  logic                        rul_vld;
  logic signed [NUM_SUM_W-1:0] rul_num;
  logic [WSUM_W-1:0]           rul_den;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LVL_NM: lvl_q[0] <= cfg_wdata_i;
        REG_LVL_NS: lvl_q[1] <= cfg_wdata_i;
        REG_LVL_ZE: lvl_q[2] <= cfg_wdata_i;
        REG_LVL_PS: lvl_q[3] <= cfg_wdata_i;
        REG_LVL_PM: lvl_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fzc_grade u_grade (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .pos_x_i   (pos_x_i),
    .angle_y_i (angle_y_i),
    .valid_o   (grd_vld),
    .gx_o      (gx),
    .gy_o      (gy)
  );

  fzc_rules #(.NUM_RULES(NUM_RULES)) u_rules (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (grd_vld),
    .gx_i    (gx),
    .gy_i    (gy),
    .lvl_i   (lvl_q),
    .valid_o (rul_vld),
    .num_o   (rul_num),
    .den_o   (rul_den)
  );

  fzc_div #(.MIN_WEIGHT_SUM(MIN_WEIGHT_SUM)) u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (rul_vld),
    .num_i           (rul_num),
    .den_i           (rul_den),
    .valid_o         (done_o),
    .drive_force_o   (drive_force_o),
    .no_rule_fired_o (no_rule_fired_o)
  );

  `FZC_ASSERT_IMPL(a_start_to_done, start_i, ##LATENCY done_o, "transaction lost in pipeline")
  `FZC_ASSERT_IMPL(a_done_from_start, done_o, $past(start_i, LATENCY), "result without sample")
  `FZC_ASSERT_ALWAYS(a_weak_zero, !(done_o && no_rule_fired_o) || drive_force_o == '0, "weak firing drive not zero")

endmodule
